// ===== design/assert_macros.svh =====
// Assertion shorthands shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define BRE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("bre assertion failed");

// Checked on every clock edge, reset included.
`define BRE_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("bre assertion failed, reset included");

`endif

// ===== design/bre_pkg.sv =====
package bre_pkg;

  localparam int MASK_W  = 64;
  localparam int SCAN_W  = MASK_W + 1;
  localparam int POS_W   = 6;
  localparam int LEN_W   = 7;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  typedef struct packed {
    logic [POS_W-1:0] start;
    logic [LEN_W-1:0] endp1;
    logic             more;
  } run_info_t;

  // index of the lowest set bit; 0 if v is all zero
  function automatic logic [LEN_W-1:0] ctz(input logic [SCAN_W-1:0] v);
    logic [LEN_W-1:0] pos;
    pos = '0;
    for (int i = SCAN_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        pos = LEN_W'(i);
      end
    end
    return pos;
  endfunction

endpackage

// ===== design/bre_in_if.sv =====
interface bre_in_if import bre_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MASK_W-1:0] mask;

  modport source (output valid, output mask, input ready);
  modport sink   (input valid, input mask, output ready);
endinterface

// ===== design/bre_out_if.sv =====
interface bre_out_if import bre_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] run_start;
  logic [POS_W-1:0] run_end;
  logic [LEN_W-1:0] run_length;
  logic [POS_W-1:0] hole_before;
  logic             first_run;
  logic             last;
  logic             empty_res;

  modport source (output valid, output run_start, output run_end, output run_length,
                  output hole_before, output first_run, output last, output empty_res,
                  input ready);
  modport sink   (input valid, input run_start, input run_end, input run_length,
                  input hole_before, input first_run, input last, input empty_res,
                  output ready);
endinterface

// ===== design/bre_run_finder.sv =====
module bre_run_finder
  import bre_pkg::*;
#(
  parameter int W = 64
) (
  input  logic [W-1:0] mask,
  output logic [W-1:0] mask_rest,
  output run_info_t    info
);

  logic [W-1:0] dec;
  logic [W-1:0] lowbit;
  logic [W-1:0] holes;
  logic [W:0]   holes_ext;
  logic [LEN_W-1:0] start_pos;

  // dec clears the lowest set bit and fills the zeros below it
  assign dec       = mask - W'(1);
  assign lowbit    = mask & ~dec;
  assign holes     = ~mask & ~dec;
  assign holes_ext = {1'b1, holes};
  assign mask_rest = mask & (mask + lowbit);

  assign start_pos  = ctz(SCAN_W'(mask));
  assign info.start = start_pos[POS_W-1:0];
  assign info.endp1 = ctz(SCAN_W'(holes_ext));
  assign info.more  = |mask_rest;

endmodule

// ===== design/bitmask_run_extractor_core.sv =====
// Bitmask run extractor.
// in_chan carries one cache-line access mask per item (valid/ready); only the
// low MASK_WIDTH bits are looked at. out_chan carries one item per maximal run
// of set bits, lowest run first: start, end, length, clear bits since the
// previous run, first_run, and last on the final run. An all-clear mask gives
// one item with empty_res and last set and the other fields zero.
// Timing: the mask is registered, then one run is found per cycle while the
// output register is free, by a single subtract/add/priority-encode unit. A
// mask holds the block until its last item is loaded (one item per run, up to
// MASK_WIDTH/2, or one for an all-clear mask); results go to the output register.
// in_chan.ready is high only between masks. Results pass through one output
// register: a stalled receiver holds the current result and freezes the scan
// until it is taken, with no loss.
// Reset (rst_n low, synchronous) drops any mask in progress and any result
// still in the output register; the block then waits for a mask.
module bitmask_run_extractor_core
  import bre_pkg::*;
#(
  parameter int MASK_WIDTH = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  bre_in_if.sink    in_chan,
  bre_out_if.source out_chan
);

  state_t              state_r, state_nxt;
  logic [MASK_WIDTH-1:0] m_r, m_nxt;
  logic                first_r, first_nxt;
  logic [LEN_W-1:0]    prev_endp1_r, prev_endp1_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [POS_W-1:0]    run_start_r, run_start_nxt;
  logic [POS_W-1:0]    run_end_r, run_end_nxt;
  logic [LEN_W-1:0]    run_length_r, run_length_nxt;
  logic [POS_W-1:0]    hole_before_r, hole_before_nxt;
  logic                first_run_r, first_run_nxt;
  logic                last_r, last_nxt;
  logic                empty_res_r, empty_res_nxt;

  logic [MASK_WIDTH-1:0] mask_rest;
  run_info_t             info;
  logic                  slot_free;
  logic                  load;
  logic [LEN_W-1:0]      hole_full;
  logic [LEN_W-1:0]      end_full;

  bre_run_finder #(.W(MASK_WIDTH)) u_finder (
    .mask      (m_r),
    .mask_rest (mask_rest),
    .info      (info)
  );

  assign in_chan.ready = (state_r == S_IDLE);
  assign slot_free     = !out_valid_r || out_chan.ready;
  assign hole_full     = LEN_W'(info.start) - prev_endp1_r;
  assign end_full      = info.endp1 - LEN_W'(1);

  always_comb begin
    state_nxt       = state_r;
    m_nxt           = m_r;
    first_nxt       = first_r;
    prev_endp1_nxt  = prev_endp1_r;
    load            = 1'b0;
    run_start_nxt   = run_start_r;
    run_end_nxt     = run_end_r;
    run_length_nxt  = run_length_r;
    hole_before_nxt = hole_before_r;
    first_run_nxt   = first_run_r;
    last_nxt        = last_r;
    empty_res_nxt   = empty_res_r;
    case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          m_nxt     = in_chan.mask[MASK_WIDTH-1:0];
          first_nxt = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (slot_free) begin
          load = 1'b1;
          if (m_r == '0) begin
            run_start_nxt   = '0;
            run_end_nxt     = '0;
            run_length_nxt  = '0;
            hole_before_nxt = '0;
            first_run_nxt   = 1'b0;
            last_nxt        = 1'b1;
            empty_res_nxt   = 1'b1;
            state_nxt       = S_IDLE;
          end else begin
            run_start_nxt   = info.start;
            run_end_nxt     = end_full[POS_W-1:0];
            run_length_nxt  = info.endp1 - LEN_W'(info.start);
            hole_before_nxt = first_r ? '0 : hole_full[POS_W-1:0];
            first_run_nxt   = first_r;
            last_nxt        = !info.more;
            empty_res_nxt   = 1'b0;
            m_nxt           = mask_rest;
            first_nxt       = 1'b0;
            prev_endp1_nxt  = info.endp1;
            if (!info.more) begin
              state_nxt = S_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    out_valid_nxt = load || (out_valid_r && !out_chan.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    m_r           <= m_nxt;
    first_r       <= first_nxt;
    prev_endp1_r  <= prev_endp1_nxt;
    run_start_r   <= run_start_nxt;
    run_end_r     <= run_end_nxt;
    run_length_r  <= run_length_nxt;
    hole_before_r <= hole_before_nxt;
    first_run_r   <= first_run_nxt;
    last_r        <= last_nxt;
    empty_res_r   <= empty_res_nxt;
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.run_start   = run_start_r;
  assign out_chan.run_end     = run_end_r;
  assign out_chan.run_length  = run_length_r;
  assign out_chan.hole_before = hole_before_r;
  assign out_chan.first_run   = first_run_r;
  assign out_chan.last        = last_r;
  assign out_chan.empty_res   = empty_res_r;

endmodule

// ===== design/bre_checker.sv =====
`include "assert_macros.svh"

module bre_checker
  import bre_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [POS_W-1:0] run_start,
  input logic [POS_W-1:0] run_end,
  input logic [LEN_W-1:0] run_length,
  input logic [POS_W-1:0] hole_before,
  input logic             first_run,
  input logic             last,
  input logic             empty_res
);

  logic [LEN_W-1:0] span;

  assign span = LEN_W'(run_end) - LEN_W'(run_start) + LEN_W'(1);

  // busy after taking a mask
  `BRE_ASSERT(a_busy_after_accept, in_valid && in_ready |=> !in_ready)

  // a stalled result stays put
  `BRE_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(run_start) && $stable(run_end) && $stable(last))

  // empty mask result: last, everything else zero
  `BRE_ASSERT(a_empty_shape, out_valid && empty_res |-> last && !first_run && run_length == '0 && run_start == '0 && hole_before == '0)

  // run length agrees with its bounds, first run has no hole
  `BRE_ASSERT(a_run_shape, out_valid && !empty_res |-> run_length == span && (!first_run || hole_before == '0))

endmodule

bind bitmask_run_extractor_core bre_checker u_bre_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_chan.valid),
  .in_ready    (in_chan.ready),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .run_start   (out_chan.run_start),
  .run_end     (out_chan.run_end),
  .run_length  (out_chan.run_length),
  .hole_before (out_chan.hole_before),
  .first_run   (out_chan.first_run),
  .last        (out_chan.last),
  .empty_res   (out_chan.empty_res)
);

// ===== dv/bre_run_tracker.sv =====
`timescale 1ns / 1ps

module bre_run_tracker
  import bre_pkg::*;
#(
  parameter int WIDTH = 64
) (
  input  logic clk,
  input  logic rst_n,
  bre_in_if    in_mon,
  bre_out_if   out_mon,
  output int   fail_count,
  output int   runs_due_count,
  output int   runs_checked
);

  typedef struct packed {
    logic [POS_W-1:0] run_start;
    logic [POS_W-1:0] run_end;
    logic [LEN_W-1:0] run_length;
    logic [POS_W-1:0] hole_before;
    logic             first_run;
    logic             last;
    logic             empty_res;
  } run_t;

  run_t runs_due[$];

  // one run is held back so that the final one can carry last
  function automatic void split_runs(input logic [MASK_W-1:0] m);
    run_t held;
    run_t r;
    bit   have_held;
    bit   in_run;
    bit   b;
    int   cur;
    int   prev_end;
    held      = '0;
    r         = '0;
    have_held = 1'b0;
    in_run    = 1'b0;
    cur       = 0;
    prev_end  = 0;
    for (int i = 0; i <= WIDTH; i++) begin
      b = (i < WIDTH) ? m[i] : 1'b0;
      if (b && !in_run) begin
        in_run = 1'b1;
        cur    = i;
      end else if (!b && in_run) begin
        in_run        = 1'b0;
        r.run_start   = POS_W'(cur);
        r.run_end     = POS_W'(i - 1);
        r.run_length  = LEN_W'(i - cur);
        r.hole_before = have_held ? POS_W'(cur - prev_end - 1) : '0;
        r.first_run   = !have_held;
        r.last        = 1'b0;
        r.empty_res   = 1'b0;
        if (have_held) begin
          runs_due.insert(runs_due.size(), held);
        end
        held      = r;
        have_held = 1'b1;
        prev_end  = i - 1;
      end
    end
    if (!have_held) begin
      held           = '0;
      held.empty_res = 1'b1;
    end
    held.last = 1'b1;
    runs_due.insert(runs_due.size(), held);
  endfunction

  function automatic bit field_ok(input string fname, input int unsigned want,
                                  input int unsigned got);
    if (want == got) begin
      return 1'b1;
    end
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
    return 1'b0;
  endfunction

  always @(posedge clk) begin : watch
    run_t want;
    bit   ok;
    if (rst_n) begin
      if (out_mon.valid && out_mon.ready) begin
        runs_checked++;
        if (runs_due.size() == 0) begin
          $display("%0t: unexpected run item, start %0d end %0d empty %0d", $time,
                   out_mon.run_start, out_mon.run_end, out_mon.empty_res);
          fail_count++;
        end else begin
          want = runs_due.pop_front();
          ok = field_ok("run_start", want.run_start, out_mon.run_start);
          ok &= field_ok("run_end", want.run_end, out_mon.run_end);
          ok &= field_ok("run_length", want.run_length, out_mon.run_length);
          ok &= field_ok("hole_before", want.hole_before, out_mon.hole_before);
          ok &= field_ok("first_run", want.first_run, out_mon.first_run);
          ok &= field_ok("last", want.last, out_mon.last);
          ok &= field_ok("empty_res", want.empty_res, out_mon.empty_res);
          if (!ok) begin
            fail_count++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        split_runs(in_mon.mask);
      end
    end
    runs_due_count <= runs_due.size();
  end

endmodule

// ===== dv/bitmask_run_extractor_core_test.sv =====
`timescale 1ns / 1ps

module bitmask_run_extractor_core_test;
  import bre_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;

  logic clk;
  logic rst_n;
  int   src_idle;
  int   sink_idle;
  int   hold_reqs;
  int   masks_sent;
  int   empties_sent;
  int   fail_count;
  int   runs_due_count;
  int   runs_checked;

  bre_in_if  in_chan ();
  bre_out_if out_chan ();

  bitmask_run_extractor_core #(
    .MASK_WIDTH(MASK_W)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  bre_run_tracker #(
    .WIDTH(MASK_W)
  ) run_tracker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_chan),
    .out_mon       (out_chan),
    .fail_count    (fail_count),
    .runs_due_count(runs_due_count),
    .runs_checked  (runs_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    for (int cyc = 0; cyc < CYCLE_LIMIT; cyc++) begin
      @(posedge clk);
    end
    $display("timeout after %0d cycles, %0d run items still due", CYCLE_LIMIT,
             runs_due_count);
    $display("*** FAILED ***");
    $finish;
  end

  // a requested hold keeps ready low until hold_left counts down to zero
  initial begin : receiver
    int hold_served;
    int hold_left;
    hold_served = 0;
    hold_left   = 0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && hold_served != hold_reqs) begin
        hold_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= ($urandom_range(99) >= sink_idle);
      end
    end
  end

  function automatic logic [MASK_W-1:0] pick_mask();
    logic [MASK_W-1:0] m;
    logic [MASK_W-1:0] one;
    int                p;
    int                len;
    int                s;
    one = MASK_W'(1);
    m   = '0;
    case ($urandom_range(6))
      0: m = {$urandom, $urandom};
      1: m = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
      2: m = {$urandom, $urandom} | {$urandom, $urandom} | {$urandom, $urandom};
      3: begin
        p = $urandom_range(5);
        while (p < MASK_W) begin
          len = $urandom_range(1, ($urandom_range(3) == 0) ? 20 : 4);
          for (int k = 0; k < len && p < MASK_W; k++) begin
            m[p] = 1'b1;
            p++;
          end
          p += $urandom_range(1, ($urandom_range(3) == 0) ? 20 : 4);
        end
      end
      4: begin
        s   = $urandom_range(MASK_W - 1);
        len = $urandom_range(1, MASK_W - s);
        m   = ((one << len) - one) << s;
      end
      5: begin
        m = {32{2'b01}} << $urandom_range(1);
        m ^= one << $urandom_range(MASK_W - 1);
      end
      default: m = $urandom_range(1) ? {MASK_W{1'b0}} : {MASK_W{1'b1}};
    endcase
    return m;
  endfunction

  task automatic send_mask(input logic [MASK_W-1:0] m);
    while ($urandom_range(99) < src_idle) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.mask  <= m;
    do @(posedge clk); while (!in_chan.ready);
    masks_sent++;
    if (m == '0) begin
      empties_sent++;
    end
  endtask

  task automatic drain();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (runs_due_count != 0) begin
      @(posedge clk);
    end
  endtask

  initial begin : stimulus
    src_idle     = 13;
    sink_idle    = 76;
    hold_reqs    = 0;
    masks_sent   = 0;
    empties_sent = 0;
    in_chan.valid <= 1'b0;
    in_chan.mask  <= '0;
    rst_n         <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    send_mask(64'h0000_0000_0000_0000);
    send_mask(64'hFFFF_FFFF_FFFF_FFFF);
    send_mask(64'h0000_0000_0000_0001);
    send_mask(64'h8000_0000_0000_0000);
    send_mask(64'h5555_5555_5555_5555);
    send_mask(64'hAAAA_AAAA_AAAA_AAAA);
    send_mask(64'h8000_0000_0000_0001);
    send_mask(64'hFFFF_FFFF_0000_0000);
    send_mask(64'h0000_0000_FFFF_FFFF);
    send_mask(64'h7FFF_FFFF_FFFF_FFFE);
    send_mask(64'h0000_0001_8000_0000);
    send_mask(64'hC000_0000_0000_0003);
    send_mask(64'h00FF_00FF_00FF_00FF);
    send_mask(64'hF0F0_F0F0_F0F0_F0F0);
    send_mask(64'h0000_0000_0000_0003);
    send_mask(64'h0000_0000_0000_0006);

    repeat (98) send_mask(pick_mask());

    // long output stall while masks keep coming, then wait for the backlog
    hold_reqs++;
    repeat (20) send_mask(pick_mask());
    drain();

    src_idle  = 76;
    sink_idle = 13;
    repeat (98) send_mask(pick_mask());
    drain();

    src_idle  = 0;
    sink_idle = 0;
    repeat (98) send_mask(pick_mask());
    drain();
    repeat (40) @(posedge clk);

    $display("Sent %0d masks (%0d all clear) through three idling mixes and a %0d-cycle stall",
             masks_sent, empties_sent, HOLD_CYCLES);
    $display("Checked %0d run items field by field, %0d failing", runs_checked, fail_count);
    if (fail_count == 0 && runs_due_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
